>>> src/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types and constants of the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_W      = 64;      // width of a chunk size
    localparam int DIGIT_CNT_W = 5;       // digit counter and limit width
    localparam logic [DIGIT_CNT_W-1:0] MAX_DIGITS = DIGIT_CNT_W'(16);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [3:0] {
        PH_SIZE    = 4'd0,
        PH_SIZE_LF = 4'd1,
        PH_DATA    = 4'd2,
        PH_TRAIL_A = 4'd3,
        PH_TRAIL_B = 4'd4,
        PH_END_CR  = 4'd5,
        PH_END_LF  = 4'd6,
        PH_DONE    = 4'd7,
        PH_ERROR   = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_NEED_MORE  = 3'd0,
        ST_PAYLOAD    = 3'd1,
        ST_SIZE_DONE  = 3'd2,
        ST_LAST_SIZE  = 3'd3,
        ST_CHUNK_DONE = 3'd4,
        ST_BODY_DONE  = 3'd5,
        ST_ERROR      = 3'd6,
        ST_IGNORED    = 3'd7
    } t_status;

    // classified input byte, as queued between front and back
    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_item;

    // handshake between the queue and the executing back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

endpackage

>>> src/hcbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_front
// byte classifier and two-entry queue towards the back end
// ----------------------------------------------------------------------------
module hcbd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_data_byte,
    input  logic                i_start_body,
    output hcbd_pkg::t_queue_out o_q,
    input  logic                i_q_pop
);
    import hcbd_pkg::*;

    t_item      cls;
    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       wr_en, rd_en;

    // classification
    always_comb begin
        cls         = '0;
        cls.start   = i_start_body;
        cls.data    = i_data_byte;
        cls.is_cr   = (i_data_byte == CH_CR);
        cls.is_lf   = (i_data_byte == CH_LF);
        if (i_data_byte >= 8'h30 && i_data_byte <= 8'h39) begin
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(i_data_byte - 8'h30);
        end else if (i_data_byte >= 8'h41 && i_data_byte <= 8'h46) begin
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(i_data_byte - 8'h37);
        end else if (i_data_byte >= 8'h61 && i_data_byte <= 8'h66) begin
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'(i_data_byte - 8'h57);
        end
    end

    assign full    = (r_count == 2'd2);
    assign wr_en   = push && !full;
    assign rd_en   = i_q_pop && (r_count != 2'd0);
    assign o_q     = '{valid: (r_count != 2'd0), item: r_mem[r_rptr]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (wr_en) r_wptr <= ~r_wptr;
            if (rd_en) r_rptr <= ~r_rptr;
            unique case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_pop && r_count == 2'd0 && !wr_en) |=> (r_count == 2'd0))
        else $error("pop of empty queue changed count");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !rd_en) |=> (r_count == 2'd2))
        else $error("full queue lost an entry");

endmodule

>>> src/hcbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_back
// chunk phase machine and result register
// ----------------------------------------------------------------------------
module hcbd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [4:0]                 i_cfg_wdata,
    input  hcbd_pkg::t_queue_out       i_q,
    output logic                       o_q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic [2:0]                 o_status,
    output logic [7:0]                 o_payload_byte,
    output logic [hcbd_pkg::SIZE_W-1:0] o_chunk_length
);
    import hcbd_pkg::*;

    t_phase                 r_phase, n_phase, cur_phase;
    logic [SIZE_W-1:0]      r_accum, n_accum, cur_accum;
    logic [SIZE_W-1:0]      r_left, n_left, cur_left, dec_left;
    logic [DIGIT_CNT_W-1:0] r_digits, n_digits, cur_digits;
    logic [DIGIT_CNT_W-1:0] r_limit;
    logic                   r_out_valid;
    t_status                r_status, n_status;
    logic [7:0]             r_pay, n_pay;
    logic [SIZE_W-1:0]      r_len, n_len;
    logic                   take;
    t_item                  it;

    assign it      = i_q.item;
    assign o_q_pop = i_q.valid && (!r_out_valid || pop);
    assign take    = o_q_pop;

    // limit kept already clamped to 1..16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= MAX_DIGITS;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata == '0)             r_limit <= DIGIT_CNT_W'(1);
            else if (i_cfg_wdata > MAX_DIGITS) r_limit <= MAX_DIGITS;
            else                               r_limit <= i_cfg_wdata;
        end
    end

    always_comb begin
        cur_phase  = it.start ? PH_SIZE : r_phase;
        cur_accum  = it.start ? '0 : r_accum;
        cur_left   = it.start ? '0 : r_left;
        cur_digits = it.start ? '0 : r_digits;
        dec_left   = (cur_left != '0) ? cur_left - SIZE_W'(1) : cur_left;

        n_phase  = cur_phase;
        n_accum  = cur_accum;
        n_left   = cur_left;
        n_digits = cur_digits;
        n_status = ST_NEED_MORE;
        n_pay    = '0;
        n_len    = '0;

        unique case (cur_phase)
            PH_SIZE: begin
                if (it.is_cr) begin
                    n_phase = PH_SIZE_LF;
                end else if (!it.is_hex || cur_digits >= r_limit ||
                             cur_accum[SIZE_W-1 -: 4] != 4'd0) begin
                    n_phase  = PH_ERROR;
                    n_status = ST_ERROR;
                end else begin
                    n_accum  = {cur_accum[SIZE_W-5:0], it.hex_val};
                    n_digits = cur_digits + DIGIT_CNT_W'(1);
                end
            end
            PH_SIZE_LF: begin
                if (!it.is_lf) begin
                    n_phase  = PH_ERROR;
                    n_status = ST_ERROR;
                end else if (cur_accum == '0) begin
                    n_phase  = PH_END_CR;
                    n_status = ST_LAST_SIZE;
                end else begin
                    n_phase  = PH_DATA;
                    n_left   = cur_accum;
                    n_status = ST_SIZE_DONE;
                    n_len    = cur_accum;
                end
            end
            PH_DATA: begin
                n_status = ST_PAYLOAD;
                n_pay    = it.data;
                n_left   = dec_left;
                if (dec_left == '0) n_phase = PH_TRAIL_A;
            end
            PH_TRAIL_A: begin
                n_phase = PH_TRAIL_B;
            end
            PH_TRAIL_B: begin
                n_phase  = PH_SIZE;
                n_accum  = '0;
                n_left   = '0;
                n_digits = '0;
                n_status = ST_CHUNK_DONE;
            end
            PH_END_CR: begin
                if (it.is_cr) begin
                    n_phase = PH_END_LF;
                end else begin
                    n_phase  = PH_ERROR;
                    n_status = ST_ERROR;
                end
            end
            PH_END_LF: begin
                if (it.is_lf) begin
                    n_phase  = PH_DONE;
                    n_status = ST_BODY_DONE;
                end else begin
                    n_phase  = PH_ERROR;
                    n_status = ST_ERROR;
                end
            end
            PH_DONE: begin
                n_status = ST_IGNORED;
            end
            default: begin
                n_phase  = PH_ERROR;
                n_status = ST_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIZE;
            r_accum     <= '0;
            r_left      <= '0;
            r_digits    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase  <= n_phase;
                r_accum  <= n_accum;
                r_left   <= n_left;
                r_digits <= n_digits;
            end
            if (take)     r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= n_status;
            r_pay    <= n_pay;
            r_len    <= n_len;
        end
    end

    assign empty          = !r_out_valid;
    assign o_status       = r_status;
    assign o_payload_byte = r_pay;
    assign o_chunk_length = r_len;

    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_PAYLOAD) |-> (r_pay == 8'd0))
        else $error("payload byte set outside payload status");
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_SIZE_DONE) |-> (r_len == '0))
        else $error("chunk length set outside size_done");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == PH_ERROR && !it.start) |=> (r_phase == PH_ERROR))
        else $error("error phase left without restart");
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= MAX_DIGITS)
        else $error("digit count beyond limit");

endmodule

>>> src/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// a pushed byte is written into the front queue, then its result into the result register
// throughput: one byte per cycle while the result side pops, push and pop may both happen every cycle
// the two-entry front queue and the result register let either side stall alone
// reset (i_rst_n low at a clock edge, synchronous) empties both sides,
// returns to a fresh size line and sets the digit limit to sixteen
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// byte-wide http/1.1 chunked transfer decoder, one result per input byte
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: digit limit of a size line
    input  logic                        i_cfg_we,
    input  logic [4:0]                  i_cfg_wdata,
    // input transactions
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_start_body,
    // result transactions
    output logic                        empty,
    input  logic                        pop,
    output logic [2:0]                  o_status,
    output logic [7:0]                  o_payload_byte,
    output logic [hcbd_pkg::SIZE_W-1:0] o_chunk_length
);
    import hcbd_pkg::*;

    t_queue_out q;      // head of the classified byte queue
    logic       q_pop;  // back end takes the head

    // front: classify each byte (cr, lf, hex digit) and queue it
    hcbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .i_start_body (i_start_body),
        .o_q          (q),
        .i_q_pop      (q_pop)
    );

    // back: phase machine, size accumulation, payload countdown,
    // and the result register that the result side pops
    hcbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q            (q),
        .o_q_pop        (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_payload_byte (o_payload_byte),
        .o_chunk_length (o_chunk_length)
    );

    // every queued byte leaves only into a free or freeing result register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |-> !q_pop)
        else $error("result overwritten before it was taken");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the chunked body decoder: a directed table of size
// lines, payload, trailers and malformed bytes, then random bodies under
// several digit limits, every result compared with its table entry or an untimed decoder model
// ----------------------------------------------------------------------------
module testbench;
    import hcbd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;   // far above the slowest correct run
    localparam int PHASE_BYTES = 190;      // minimum random bytes per digit limit setting
    localparam int N_DIRECTED  = 27;

    // one decoder result, as predicted or as seen on the ports
    typedef struct {
        t_status     status;
        logic [7:0]  payload;
        logic [63:0] length;
    } t_result;

    // one input transaction of a generated body
    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_byte_in;

    // directed row: the byte, and the result where it is obvious
    typedef struct {
        logic [7:0]  data;
        logic        start;
        bit          typed;
        t_status     status;
        logic [7:0]  payload;
        logic [63:0] length;
    } t_dir_row;

    // ------------------------------------------------------------------------
    // block ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [4:0]        i_cfg_wdata    = 5'd0;
    logic              push           = 1'b0;
    logic              full;
    logic [7:0]        i_data_byte    = 8'h00;
    logic              i_start_body   = 1'b0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [2:0]        o_status;
    logic [7:0]        o_payload_byte;
    logic [SIZE_W-1:0] o_chunk_length;

    http_chunked_body_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_start_body   (i_start_body),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_payload_byte (o_payload_byte),
        .o_chunk_length (o_chunk_length)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // decoder model: own copy of the parse state and of the digit limit
    // ------------------------------------------------------------------------
    t_phase      dec_phase       = PH_SIZE;
    logic [63:0] size_acc        = '0;
    logic [4:0]  digits_seen     = '0;
    logic [63:0] bytes_remaining = '0;
    logic [4:0]  digit_limit     = MAX_DIGITS;

    t_result     pending_results [$];   // predicted results not yet popped
    int          mismatch_count  = 0;
    int          bytes_sent      = 0;
    int          tx_idle_pct     = 20;
    int          rx_stall_pct    = 20;

    // back to a fresh size line
    function automatic void restart_line();
        dec_phase       = PH_SIZE;
        size_acc        = '0;
        digits_seen     = '0;
        bytes_remaining = '0;
    endfunction

    // result of one byte, advancing the model state
    function automatic t_result decode_byte(logic [7:0] b, logic start);
        t_result    r;
        logic [3:0] nib;
        logic [4:0] lim;
        bit         is_hex;
        r.status  = ST_NEED_MORE;
        r.payload = 8'h00;
        r.length  = '0;
        is_hex    = 1'b1;
        nib       = 4'h0;
        if (b >= 8'h30 && b <= 8'h39) nib = 4'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h46) nib = 4'(b - 8'h37);
        else if (b >= 8'h61 && b <= 8'h66) nib = 4'(b - 8'h57);
        else is_hex = 1'b0;
        // a limit of zero acts as one, anything above sixteen as sixteen
        lim = (digit_limit == 5'd0) ? 5'd1 :
              (digit_limit > MAX_DIGITS) ? MAX_DIGITS : digit_limit;
        if (start) restart_line();
        case (dec_phase)
            PH_SIZE: begin
                if (b == CH_CR) begin
                    dec_phase = PH_SIZE_LF;
                end else if (!is_hex || digits_seen >= lim || size_acc[63:60] != 4'h0) begin
                    dec_phase = PH_ERROR;
                    r.status  = ST_ERROR;
                end else begin
                    size_acc    = {size_acc[59:0], nib};
                    digits_seen = digits_seen + 5'd1;
                end
            end
            PH_SIZE_LF: begin
                if (b != CH_LF) begin
                    dec_phase = PH_ERROR;
                    r.status  = ST_ERROR;
                end else if (size_acc == '0) begin
                    dec_phase = PH_END_CR;
                    r.status  = ST_LAST_SIZE;
                end else begin
                    dec_phase       = PH_DATA;
                    bytes_remaining = size_acc;
                    r.status        = ST_SIZE_DONE;
                    r.length        = size_acc;
                end
            end
            PH_DATA: begin
                r.status  = ST_PAYLOAD;
                r.payload = b;
                if (bytes_remaining != '0) bytes_remaining = bytes_remaining - 64'd1;
                if (bytes_remaining == '0) dec_phase = PH_TRAIL_A;
            end
            // trailer bytes pass unchecked
            PH_TRAIL_A: dec_phase = PH_TRAIL_B;
            PH_TRAIL_B: begin
                restart_line();
                r.status = ST_CHUNK_DONE;
            end
            PH_END_CR: begin
                if (b == CH_CR) begin
                    dec_phase = PH_END_LF;
                end else begin
                    dec_phase = PH_ERROR;
                    r.status  = ST_ERROR;
                end
            end
            PH_END_LF: begin
                if (b == CH_LF) begin
                    dec_phase = PH_DONE;
                    r.status  = ST_BODY_DONE;
                end else begin
                    dec_phase = PH_ERROR;
                    r.status  = ST_ERROR;
                end
            end
            PH_DONE: r.status = ST_IGNORED;
            // error phase is sticky, unused encodings behave the same
            default: begin
                dec_phase = PH_ERROR;
                r.status  = ST_ERROR;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // result side: check each popped transaction, stall in random bursts
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none pending, status %0d", o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %s",
                                              o_status, want.status.name()));
                if (o_payload_byte !== want.payload)
                    report_mismatch($sformatf("payload %02h, wanted %02h",
                                              o_payload_byte, want.payload));
                if (o_chunk_length !== want.length)
                    report_mismatch($sformatf("chunk length %0h, wanted %0h",
                                              o_chunk_length, want.length));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if ($urandom_range(1, 100) <= rx_stall_pct) begin
            stall_left = $urandom_range(0, 4);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // run guard
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one input transaction; push stays high into the next byte unless idling
    task automatic send_byte(logic [7:0] b, logic start, bit typed, t_result typed_res);
        t_result model_res;
        if ($urandom_range(1, 100) <= tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_start_body <= start;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // the model always runs so its state follows the stream
        model_res = decode_byte(b, start);
        pending_results.push_back(typed ? typed_res : model_res);
        bytes_sent++;
    endtask

    // let the block drain completely, then change the digit limit
    task automatic write_digit_limit(logic [4:0] value);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        digit_limit = value;
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // random body generation
    // ------------------------------------------------------------------------
    t_byte_in body_bytes [$];

    function automatic void add_byte(logic [7:0] b, logic start);
        t_byte_in x;
        x.data  = b;
        x.start = start;
        body_bytes.push_back(x);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    // size line of n_digits digits, leading zeros as needed, then cr lf
    function automatic void add_size_line(logic [63:0] value, int n_digits);
        for (int i = n_digits - 1; i >= 0; i--)
            add_byte(hex_char(4'(value >> (4 * i))), 1'b0);
        add_byte(CH_CR, 1'b0);
        add_byte(CH_LF, 1'b0);
    endfunction

    task automatic build_body();
        int          lim;
        int          kind;
        int          len;
        int          n_dig;
        int          idx;
        logic [63:0] big;
        body_bytes.delete();
        lim  = (digit_limit == 5'd0) ? 1 : (digit_limit > MAX_DIGITS) ? 16 : int'(digit_limit);
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            // well-formed body of a few short chunks
            repeat ($urandom_range(0, 3)) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                if (lim == 1 && len > 15) len = 15;
                n_dig = (len > 15) ? 2 : 1;
                add_size_line(64'(len), $urandom_range(n_dig, lim));
                repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
                // trailer is usually cr lf, but anything passes
                if ($urandom_range(0, 2) != 0) begin
                    add_byte(CH_CR, 1'b0);
                    add_byte(CH_LF, 1'b0);
                end else begin
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            // last chunk: zero size, or an empty size line
            if ($urandom_range(0, 3) != 0) begin
                add_size_line(64'd0, $urandom_range(1, lim));
            end else begin
                add_byte(CH_CR, 1'b0);
                add_byte(CH_LF, 1'b0);
            end
            add_byte(CH_CR, 1'b0);
            add_byte(CH_LF, 1'b0);
            // bytes after the end are ignored
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)), 1'b0);
            // broken body: one byte replaced, sometimes with a stray restart
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(1, body_bytes.size() - 1);
                body_bytes[idx].data  = 8'($urandom_range(0, 255));
                body_bytes[idx].start = ($urandom_range(0, 3) == 0);
            end
            body_bytes[0].start = 1'b1;
        end else if (kind < 90) begin
            // widest size line the limit allows, or one digit too many
            n_dig = lim + ((kind >= 80) ? 1 : 0);
            big   = {32'($urandom), 32'($urandom)};
            if (kind == 65) big = '1;
            add_size_line(big, n_dig);
            // a few payload bytes, then the next body restarts
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)), 1'b0);
            body_bytes[0].start = 1'b1;
        end else begin
            // noise with the odd restart
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic run_phase(logic [4:0] limit_value, int idle_pct);
        t_result unused_res;
        int      goal;
        unused_res.status  = ST_NEED_MORE;
        unused_res.payload = 8'h00;
        unused_res.length  = '0;
        write_digit_limit(limit_value);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = idle_pct;
        goal = bytes_sent + PHASE_BYTES;
        while (bytes_sent < goal) begin
            build_body();
            foreach (body_bytes[i])
                send_byte(body_bytes[i].data, body_bytes[i].start, 1'b0, unused_res);
        end
    endtask

    // ------------------------------------------------------------------------
    // directed table, run at the reset digit limit of sixteen
    // ------------------------------------------------------------------------
    t_dir_row directed_rows [N_DIRECTED] = '{
        // size line "2", two payload bytes at the byte extremes, trailer
        '{8'h32,  1'b1, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_CR,  1'b0, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_LF,  1'b0, 1'b1, ST_SIZE_DONE,  8'h00, 64'd2},
        '{8'h00,  1'b0, 1'b1, ST_PAYLOAD,    8'h00, 64'd0},
        '{8'hFF,  1'b0, 1'b1, ST_PAYLOAD,    8'hFF, 64'd0},
        '{8'h78,  1'b0, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{8'h79,  1'b0, 1'b1, ST_CHUNK_DONE, 8'h00, 64'd0},
        // last chunk and the closing cr lf, then a byte past the end
        '{8'h30,  1'b0, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_CR,  1'b0, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_LF,  1'b0, 1'b1, ST_LAST_SIZE,  8'h00, 64'd0},
        '{CH_CR,  1'b0, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_LF,  1'b0, 1'b1, ST_BODY_DONE,  8'h00, 64'd0},
        '{8'h7A,  1'b0, 1'b1, ST_IGNORED,    8'h00, 64'd0},
        // empty size line, then a bad final lf and the error sticking
        '{CH_CR,  1'b1, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_LF,  1'b0, 1'b1, ST_LAST_SIZE,  8'h00, 64'd0},
        '{CH_CR,  1'b0, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{8'h00,  1'b0, 1'b1, ST_ERROR,      8'h00, 64'd0},
        '{8'h51,  1'b0, 1'b1, ST_ERROR,      8'h00, 64'd0},
        // non-hex digit, chunk extension, bare lf in a size line
        '{8'h67,  1'b1, 1'b1, ST_ERROR,      8'h00, 64'd0},
        '{8'h3B,  1'b1, 1'b1, ST_ERROR,      8'h00, 64'd0},
        '{CH_LF,  1'b1, 1'b1, ST_ERROR,      8'h00, 64'd0},
        // lower-case digit, cr without its lf
        '{8'h66,  1'b1, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_CR,  1'b0, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{8'h41,  1'b0, 1'b1, ST_ERROR,      8'h00, 64'd0},
        // lf where the final cr belongs
        '{CH_CR,  1'b1, 1'b0, ST_NEED_MORE,  8'h00, 64'd0},
        '{CH_LF,  1'b0, 1'b1, ST_LAST_SIZE,  8'h00, 64'd0},
        '{CH_LF,  1'b0, 1'b1, ST_ERROR,      8'h00, 64'd0}
    };

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_result typed_res;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            typed_res.status  = directed_rows[i].status;
            typed_res.payload = directed_rows[i].payload;
            typed_res.length  = directed_rows[i].length;
            send_byte(directed_rows[i].data, directed_rows[i].start,
                      directed_rows[i].typed, typed_res);
        end

        // random bodies under a range of digit limits, out-of-range values included
        run_phase(5'd0,  $urandom_range(0, 40));
        run_phase(5'd1,  $urandom_range(0, 40));
        run_phase(5'd31, $urandom_range(0, 40));
        run_phase(5'd4,  $urandom_range(0, 40));
        run_phase(5'd17, $urandom_range(0, 40));
        run_phase(5'($urandom_range(1, 16)), $urandom_range(0, 40));
        // last stretch at full rate on both sides
        run_phase(5'd16, 0);

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // wait on to catch any stray result
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
